/* rtl/bole_pkg.sv */
// Shared types and codes for the bounded ordered list engine.
`default_nettype none

package bole_pkg;

  localparam int unsigned DATA_W   = 8;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ECOUNT_W = 5;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MODIFY = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd4;

  // result status
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  // command broadcast to every cell
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_WRITE,
    CELL_MATCH,
    CELL_SHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [DATA_W-1:0]   key;
  } cell_ctrl_t;

  // where a cell sits relative to the requested position
  typedef struct packed {
    logic at_pos;
    logic above;
  } cell_sel_t;

endpackage

`default_nettype wire

/* rtl/bole_cell.sv */
// One list cell: holds an entry and a match flag, trades with its neighbors.
`default_nettype none

module bole_cell (
  input  wire logic                         clk_i,
  input  wire bole_pkg::cell_ctrl_t         ctrl_i,
  input  wire bole_pkg::cell_sel_t          sel_i,
  input  wire logic [bole_pkg::DATA_W-1:0]  lower_i,
  input  wire logic [bole_pkg::DATA_W-1:0]  upper_i,
  input  wire logic                         match_upper_i,
  output logic      [bole_pkg::DATA_W-1:0]  entry_o,
  output logic                              match_o
);

  logic [bole_pkg::DATA_W-1:0] entry_q, entry_d;
  logic                        match_q, match_d;

  always_comb begin
    entry_d = entry_q;
    match_d = match_q;
    case (ctrl_i.op)
      bole_pkg::CELL_INSERT: begin
        if (sel_i.at_pos) begin
          entry_d = ctrl_i.key;
        end else if (sel_i.above) begin
          entry_d = lower_i;
        end
      end
      bole_pkg::CELL_REMOVE: begin
        if (sel_i.at_pos || sel_i.above) begin
          entry_d = upper_i;
        end
      end
      bole_pkg::CELL_WRITE: begin
        if (sel_i.at_pos) begin
          entry_d = ctrl_i.key;
        end
      end
      bole_pkg::CELL_MATCH: begin
        match_d = (entry_q == ctrl_i.key);
      end
      bole_pkg::CELL_SHIFT: begin
        // match flags slide one cell toward the head per cycle
        match_d = match_upper_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= match_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

/* rtl/bounded_ordered_list_engine.sv */
// Top level of the bounded ordered list engine: request decode, cell row, result register.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------------------
//  in      | into      | in_valid_i/in_ready_o | kind_i, position_i, data_byte_i
//  out     | out of    | out_valid_o/out_ready_i | status_o, read_byte_o, found_o,
//          |           |                       | found_position_o, entry_count_o,
//          |           |                       | is_full_o, is_empty_o
//
// For insert, remove, modify and read the result is registered at the accept edge.
// Search first latches the compares in every cell, then the match flags slide toward cell 0,
// one entry at a time, until a hit or the last entry; an empty list skips the scan.
// Reset zeroes the count; entries are undefined until written and are never cleared.
// A result waits in the output register; a new request is taken in the cycle it leaves.
`default_nettype none

module bounded_ordered_list_engine #(
  parameter int unsigned LIST_DEPTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [bole_pkg::KIND_W-1:0]      kind_i,
  input  wire logic [bole_pkg::POS_W-1:0]       position_i,
  input  wire logic [bole_pkg::DATA_W-1:0]      data_byte_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [bole_pkg::STATUS_W-1:0]    status_o,
  output logic      [bole_pkg::DATA_W-1:0]      read_byte_o,
  output logic                                  found_o,
  output logic      [bole_pkg::POS_W-1:0]       found_position_o,
  output logic      [bole_pkg::ECOUNT_W-1:0]    entry_count_o,
  output logic                                  is_full_o,
  output logic                                  is_empty_o
);

  localparam int unsigned CntW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned CmpW = (CntW > bole_pkg::POS_W) ? CntW : bole_pkg::POS_W;
  localparam int unsigned EcW  = (CntW > bole_pkg::ECOUNT_W) ? CntW : bole_pkg::ECOUNT_W;
  localparam int unsigned RdN  = (LIST_DEPTH < 16) ? LIST_DEPTH : 16;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                 state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      scan_idx_q, scan_idx_d;
  logic                 out_valid_q, out_valid_d;

  logic [bole_pkg::STATUS_W-1:0] status_q;
  logic [bole_pkg::DATA_W-1:0]   read_byte_q;
  logic                          found_q;
  logic [bole_pkg::POS_W-1:0]    found_pos_q;
  logic [bole_pkg::ECOUNT_W-1:0] ecount_q;
  logic                          full_q, empty_q;

  logic [bole_pkg::DATA_W-1:0]   cell_entry [LIST_DEPTH];
  logic                          cell_match [LIST_DEPTH];
  bole_pkg::cell_ctrl_t          cell_ctrl;

  logic                 in_fire, out_fire;
  logic [CmpW-1:0]      pos_ext, cnt_ext;
  logic                 list_full;
  bole_pkg::cell_op_e   req_op;
  logic [bole_pkg::STATUS_W-1:0] req_status;
  logic [bole_pkg::DATA_W-1:0]   req_rd, rd_mux;
  logic [CntW-1:0]      cnt_next, res_cnt;
  logic                 start_scan;
  logic                 scan_hit, scan_last, scan_done, res_load;
  logic [CmpW-1:0]      fp_wide;
  logic [EcW-1:0]       ec_wide;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_q && out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);

  assign pos_ext   = CmpW'(position_i);
  assign cnt_ext   = CmpW'(count_q);
  assign list_full = (count_q == CntW'(LIST_DEPTH));

  // read port: only the first sixteen entries are addressable
  always_comb begin
    rd_mux = '0;
    for (int i = 0; i < RdN; i++) begin
      if (position_i == bole_pkg::POS_W'(i)) begin
        rd_mux = cell_entry[i];
      end
    end
  end

  always_comb begin
    req_op     = bole_pkg::CELL_HOLD;
    req_status = bole_pkg::STAT_OK;
    req_rd     = '0;
    cnt_next   = count_q;
    start_scan = 1'b0;
    case (kind_i)
      bole_pkg::KIND_INSERT: begin
        if (list_full) begin
          req_status = bole_pkg::STAT_FULL;
        end else if (pos_ext > cnt_ext) begin
          req_status = bole_pkg::STAT_RANGE;
        end else begin
          req_op   = bole_pkg::CELL_INSERT;
          cnt_next = count_q + CntW'(1);
        end
      end
      bole_pkg::KIND_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          req_status = bole_pkg::STAT_RANGE;
        end else begin
          req_op   = bole_pkg::CELL_REMOVE;
          cnt_next = count_q - CntW'(1);
        end
      end
      bole_pkg::KIND_MODIFY: begin
        if (pos_ext >= cnt_ext) begin
          req_status = bole_pkg::STAT_RANGE;
        end else begin
          req_op = bole_pkg::CELL_WRITE;
        end
      end
      bole_pkg::KIND_READ: begin
        if (pos_ext >= cnt_ext) begin
          req_status = bole_pkg::STAT_RANGE;
        end else begin
          req_rd = rd_mux;
        end
      end
      bole_pkg::KIND_SEARCH: begin
        req_op     = bole_pkg::CELL_MATCH;
        start_scan = (count_q != '0);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cell_ctrl.key = data_byte_i;
    if (in_fire) begin
      cell_ctrl.op = req_op;
    end else if (state_q == S_SCAN) begin
      cell_ctrl.op = bole_pkg::CELL_SHIFT;
    end else begin
      cell_ctrl.op = bole_pkg::CELL_HOLD;
    end
  end

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [bole_pkg::DATA_W-1:0] lower_w, upper_w;
    logic                        match_up_w;
    bole_pkg::cell_sel_t         sel_w;

    if (i == 0) begin : g_head
      assign lower_w = '0;
    end else begin : g_body
      assign lower_w = cell_entry[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_tail
      assign upper_w    = cell_entry[i];
      assign match_up_w = 1'b0;
    end else begin : g_next
      assign upper_w    = cell_entry[i+1];
      assign match_up_w = cell_match[i+1];
    end

    assign sel_w.at_pos = (CmpW'(i) == pos_ext);
    assign sel_w.above  = (CmpW'(i) > pos_ext);

    bole_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (cell_ctrl),
      .sel_i         (sel_w),
      .lower_i       (lower_w),
      .upper_i       (upper_w),
      .match_upper_i (match_up_w),
      .entry_o       (cell_entry[i]),
      .match_o       (cell_match[i])
    );
  end

  // cell 0 holds the flag for entry scan_idx_q
  assign scan_hit  = cell_match[0];
  assign scan_last = (scan_idx_q == (count_q - CntW'(1)));
  assign scan_done = (state_q == S_SCAN) && (scan_hit || scan_last);
  assign res_load  = (in_fire && !start_scan) || scan_done;

  assign fp_wide = CmpW'(scan_idx_q);
  assign res_cnt = (state_q == S_SCAN) ? count_q : cnt_next;
  assign ec_wide = EcW'(res_cnt);

  always_comb begin
    state_d     = state_q;
    scan_idx_d  = scan_idx_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (in_fire) begin
      count_d = cnt_next;
      if (start_scan) begin
        state_d    = S_SCAN;
        scan_idx_d = '0;
      end
    end
    if (state_q == S_SCAN) begin
      if (scan_done) begin
        state_d = S_IDLE;
      end else begin
        scan_idx_d = scan_idx_q + CntW'(1);
      end
    end
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_idx_q  <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_idx_q  <= scan_idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      ecount_q <= ec_wide[bole_pkg::ECOUNT_W-1:0];
      full_q   <= (res_cnt == CntW'(LIST_DEPTH));
      empty_q  <= (res_cnt == '0);
      if (state_q == S_SCAN) begin
        status_q    <= bole_pkg::STAT_OK;
        read_byte_q <= '0;
        found_q     <= scan_hit;
        found_pos_q <= scan_hit ? fp_wide[bole_pkg::POS_W-1:0] : '0;
      end else begin
        status_q    <= req_status;
        read_byte_q <= req_rd;
        found_q     <= 1'b0;
        found_pos_q <= '0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign read_byte_o      = read_byte_q;
  assign found_o          = found_q;
  assign found_position_o = found_pos_q;
  assign entry_count_o    = ecount_q;
  assign is_full_o        = full_q;
  assign is_empty_o       = empty_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(LIST_DEPTH))
    else $error("list count above depth");

  a_scan_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !out_valid_q)
    else $error("result pending during search scan");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (req_op == bole_pkg::CELL_INSERT)) |=>
      (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not grow the list");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(full_q && empty_q))
    else $error("full and empty both set");

endmodule

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the bounded ordered list engine.
`timescale 1ns / 100ps

module tb;

  localparam int LIST_DEPTH     = 16;
  localparam int RX_HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES   = 24;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 300;

  typedef struct packed {
    logic [bole_pkg::STATUS_W-1:0] status;
    logic [bole_pkg::DATA_W-1:0]   read_byte;
    logic                          found;
    logic [bole_pkg::POS_W-1:0]    found_pos;
    logic [bole_pkg::ECOUNT_W-1:0] count;
    logic                          full;
    logic                          empty;
  } list_result_t;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic [bole_pkg::KIND_W-1:0]   kind_i      = '0;
  logic [bole_pkg::POS_W-1:0]    position_i  = '0;
  logic [bole_pkg::DATA_W-1:0]   data_byte_i = '0;
  logic                          out_ready_i = 1'b0;
  logic                          in_ready_o;
  logic                          out_valid_o;
  logic [bole_pkg::STATUS_W-1:0] status_o;
  logic [bole_pkg::DATA_W-1:0]   read_byte_o;
  logic                          found_o;
  logic [bole_pkg::POS_W-1:0]    found_position_o;
  logic [bole_pkg::ECOUNT_W-1:0] entry_count_o;
  logic                          is_full_o;
  logic                          is_empty_o;

  // shadow copy of the list as the block should hold it
  logic [bole_pkg::DATA_W-1:0] list_bytes [LIST_DEPTH];
  int                          list_count = 0;

  list_result_t expected_q [$];
  list_result_t want_res;
  int           fail_cnt    = 0;
  int           cycle_cnt   = 0;
  bit           tx_idle_en  = 1'b1;
  bit           rx_idle_en  = 1'b1;
  bit           rx_hold_req = 1'b0;
  int           rx_wait     = 0;

  bounded_ordered_list_engine #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .position_i      (position_i),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .read_byte_o     (read_byte_o),
    .found_o         (found_o),
    .found_position_o(found_position_o),
    .entry_count_o   (entry_count_o),
    .is_full_o       (is_full_o),
    .is_empty_o      (is_empty_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Apply one request to the shadow list and return the result it should give.
  function automatic list_result_t apply_request(logic [bole_pkg::KIND_W-1:0] k,
                                                 logic [bole_pkg::POS_W-1:0] p,
                                                 logic [bole_pkg::DATA_W-1:0] d);
    list_result_t r;
    int i;
    r = '0;
    case (k)
      bole_pkg::KIND_INSERT: begin
        if (list_count >= LIST_DEPTH) begin
          r.status = bole_pkg::STAT_FULL;
        end else if (int'(p) > list_count) begin
          r.status = bole_pkg::STAT_RANGE;
        end else begin
          for (i = list_count; i > int'(p); i--) list_bytes[i] = list_bytes[i-1];
          list_bytes[p] = d;
          list_count++;
        end
      end
      bole_pkg::KIND_REMOVE: begin
        if (int'(p) >= list_count) begin
          r.status = bole_pkg::STAT_RANGE;
        end else begin
          for (i = int'(p); i + 1 < list_count; i++) list_bytes[i] = list_bytes[i+1];
          list_count--;
        end
      end
      bole_pkg::KIND_MODIFY: begin
        if (int'(p) >= list_count) r.status = bole_pkg::STAT_RANGE;
        else list_bytes[p] = d;
      end
      bole_pkg::KIND_READ: begin
        if (int'(p) >= list_count) r.status = bole_pkg::STAT_RANGE;
        else r.read_byte = list_bytes[p];
      end
      bole_pkg::KIND_SEARCH: begin
        for (i = 0; i < list_count; i++) begin
          if (!r.found && list_bytes[i] == d) begin
            r.found     = 1'b1;
            r.found_pos = bole_pkg::POS_W'(i);
          end
        end
      end
      default: ;
    endcase
    r.count = bole_pkg::ECOUNT_W'(list_count);
    r.full  = (list_count == LIST_DEPTH);
    r.empty = (list_count == 0);
    return r;
  endfunction

  // Called just after posedge clk_i; valid stays up from one request to the next unless a random idle gap is put in.
  task automatic push_request(input logic [bole_pkg::KIND_W-1:0] k,
                              input logic [bole_pkg::POS_W-1:0] p,
                              input logic [bole_pkg::DATA_W-1:0] d);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= k;
    position_i  <= p;
    data_byte_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(apply_request(k, p, d));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Random request steered toward a fill level.
  function automatic void pick_request(input int goal, output logic [bole_pkg::KIND_W-1:0] k,
                                       output logic [bole_pkg::POS_W-1:0] p,
                                       output logic [bole_pkg::DATA_W-1:0] d);
    int roll;
    roll = $urandom_range(0, 99);
    // small alphabet now and then so duplicates show up for search
    d = ($urandom_range(0, 2) == 0) ? bole_pkg::DATA_W'($urandom_range(0, 3))
                                    : bole_pkg::DATA_W'($urandom);
    if (roll < 5)
      k = bole_pkg::KIND_W'($urandom_range(int'(bole_pkg::KIND_SEARCH) + 1,
                                           (1 << bole_pkg::KIND_W) - 1));
    else if (roll < 45)
      k = (list_count < goal) ? bole_pkg::KIND_INSERT : bole_pkg::KIND_REMOVE;
    else if (roll < 55)
      k = ($urandom_range(0, 1) != 0) ? bole_pkg::KIND_INSERT : bole_pkg::KIND_REMOVE;
    else if (roll < 70) k = bole_pkg::KIND_MODIFY;
    else if (roll < 85) k = bole_pkg::KIND_READ;
    else                k = bole_pkg::KIND_SEARCH;
    if ($urandom_range(0, 9) == 0)      p = bole_pkg::POS_W'($urandom);
    else if (k == bole_pkg::KIND_INSERT) p = bole_pkg::POS_W'($urandom_range(0, list_count));
    else if (list_count > 0)            p = bole_pkg::POS_W'($urandom_range(0, list_count - 1));
    else                                p = bole_pkg::POS_W'($urandom);
    if (k == bole_pkg::KIND_SEARCH && list_count > 0 && $urandom_range(0, 9) < 6)
      d = list_bytes[$urandom_range(0, list_count - 1)];
  endfunction

  function automatic void check_field(string name, logic [bole_pkg::DATA_W-1:0] want,
                                      logic [bole_pkg::DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  // result checker: oldest expectation first
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("result with no request pending");
        fail_cnt++;
      end else begin
        want_res = expected_q.pop_front();
        check_field("status", bole_pkg::DATA_W'(want_res.status),
                    bole_pkg::DATA_W'(status_o));
        check_field("read_byte", want_res.read_byte, read_byte_o);
        check_field("found", bole_pkg::DATA_W'(want_res.found),
                    bole_pkg::DATA_W'(found_o));
        check_field("found_position", bole_pkg::DATA_W'(want_res.found_pos),
                    bole_pkg::DATA_W'(found_position_o));
        check_field("entry_count", bole_pkg::DATA_W'(want_res.count),
                    bole_pkg::DATA_W'(entry_count_o));
        check_field("is_full", bole_pkg::DATA_W'(want_res.full),
                    bole_pkg::DATA_W'(is_full_o));
        check_field("is_empty", bole_pkg::DATA_W'(want_res.empty),
                    bole_pkg::DATA_W'(is_empty_o));
      end
    end
  end

  // receiver: random stalls, plus a long hold on request
  always @(posedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_wait     = RX_HOLD_CYCLES;
    end else if (rx_wait == 0 && rx_idle_en && $urandom_range(0, 5) == 0) begin
      rx_wait = $urandom_range(1, 18);
    end
    if (rx_wait > 0) begin
      rx_wait--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic test_empty_list();
    push_request(bole_pkg::KIND_READ,   4'd0,  8'h00);
    push_request(bole_pkg::KIND_REMOVE, 4'd0,  8'hFF);
    push_request(bole_pkg::KIND_MODIFY, 4'd0,  8'h5A);
    push_request(bole_pkg::KIND_SEARCH, 4'd0,  8'h00);
    push_request(bole_pkg::KIND_INSERT, 4'd15, 8'hFF);
    push_request(bole_pkg::KIND_W'((1 << bole_pkg::KIND_W) - 1), 4'd15, 8'hFF);
  endtask

  task automatic test_fill_and_full();
    int i;
    push_request(bole_pkg::KIND_INSERT, 4'd0, 8'hFF);
    push_request(bole_pkg::KIND_INSERT, 4'd1, 8'h00);
    push_request(bole_pkg::KIND_INSERT, 4'd0, 8'h80);
    push_request(bole_pkg::KIND_INSERT, 4'd1, 8'h7F);
    push_request(bole_pkg::KIND_INSERT, bole_pkg::POS_W'(list_count), 8'h01);
    for (i = 0; i < LIST_DEPTH - 5; i++)
      push_request(bole_pkg::KIND_INSERT, bole_pkg::POS_W'((i * 5) % (list_count + 1)),
                   bole_pkg::DATA_W'(8'h55 ^ (i * 37)));
    // insert into a full list reports full
    push_request(bole_pkg::KIND_INSERT, 4'd3,  8'hAA);
    push_request(bole_pkg::KIND_READ,   4'd15, 8'h00);
    push_request(bole_pkg::KIND_SEARCH, 4'd0,  8'hFF);
    push_request(bole_pkg::KIND_MODIFY, 4'd15, 8'hAA);
    push_request(bole_pkg::KIND_REMOVE, 4'd0,  8'h00);
  endtask

  task automatic test_backpressure();
    logic [bole_pkg::KIND_W-1:0] k;
    logic [bole_pkg::POS_W-1:0]  p;
    logic [bole_pkg::DATA_W-1:0] d;
    int i;
    wait_drained();
    @(negedge clk_i);
    rx_hold_req = 1'b1;
    @(posedge clk_i);
    tx_idle_en = 1'b0;
    for (i = 0; i < 20; i++) begin
      pick_request(LIST_DEPTH / 2, k, p, d);
      push_request(k, p, d);
    end
    tx_idle_en = 1'b1;
    wait_drained();
    @(posedge clk_i);
  endtask

  task automatic test_random_mix();
    int goals [RANDOM_PHASES] = '{LIST_DEPTH, 2, 12, 0, LIST_DEPTH, 8};
    logic [bole_pkg::KIND_W-1:0] k;
    logic [bole_pkg::POS_W-1:0]  p;
    logic [bole_pkg::DATA_W-1:0] d;
    int ph;
    int i;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == RANDOM_PHASES - 1) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      for (i = 0; i < PHASE_ITEMS; i++) begin
        pick_request(goals[ph], k, p, d);
        push_request(k, p, d);
        // sender pause until the block has caught up
        if (ph != RANDOM_PHASES - 1 && $urandom_range(0, 149) == 0) begin
          wait_drained();
          @(posedge clk_i);
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_fill_and_full();
    test_backpressure();
    test_random_mix();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && expected_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
